### src/malc_pkg.sv
// Package for the multi-link aggregate limit controller.
// Holds widths, codes, beat and command types and the configuration view.
// No dependencies.
package malc_pkg;

   localparam int MAX_LINKS     = 3;
   localparam int GAP_HISTORY   = 16;
   localparam int LINK_W        = 2;
   localparam int GAP_IDX_W     = $clog2(GAP_HISTORY);
   localparam int GAP_CNT_W     = $clog2(GAP_HISTORY + 1);
   localparam int GAP_SUM_W     = 32 + GAP_IDX_W;
   localparam int GAP_RAM_DEPTH = MAX_LINKS * GAP_HISTORY;
   localparam int GAP_RAM_AW    = $clog2(GAP_RAM_DEPTH);
   localparam int NOW_W         = 40;
   localparam int MEAN_W        = GAP_SUM_W + 8;
   localparam int OH_W          = MEAN_W + 1;
   localparam int DIFF_W        = NOW_W + 9;
   localparam int DIV_N_W       = 112;
   localparam int DIV_D_W       = 66;
   localparam int DIV_CNT_W     = 7;
   localparam int ACC_W         = 128;
   localparam int T_W           = 91;
   localparam int CMDQ_DEPTH    = 2;
   localparam int CMDQ_PTR_W    = 1;
   localparam int CMDQ_CNT_W    = 2;

   localparam logic [31:0]      UNLIMITED    = 32'hFFFF_FFFF;
   localparam logic [NOW_W-1:0] BOOTSTRAP_US = NOW_W'(1100000);
   localparam logic [OH_W-1:0]  PHY_OH_Q8    = OH_W'(56 * 256);

   localparam logic [1:0] OP_NOTICE = 2'd0;
   localparam logic [1:0] OP_LIMIT  = 2'd1;
   localparam logic [1:0] OP_WINDOW = 2'd2;

   localparam logic [1:0] CMD_NOTICE = 2'd0;
   localparam logic [1:0] CMD_LIMIT  = 2'd1;
   localparam logic [1:0] CMD_WINDOW = 2'd2;

   localparam logic [2:0] POL_GREEDY   = 3'd1;
   localparam logic [2:0] POL_ADAPTIVE = 3'd2;
   localparam logic [2:0] POL_ONLY0    = 3'd3;
   localparam logic [2:0] POL_ONLY1    = 3'd4;
   localparam logic [2:0] POL_ONLY2    = 3'd5;
   localparam logic [2:0] POL_FIXED    = 3'd6;

   localparam logic [2:0] SRC_GREEDY  = 3'd0;
   localparam logic [2:0] SRC_BOOT    = 3'd1;
   localparam logic [2:0] SRC_ADAPT   = 3'd2;
   localparam logic [2:0] SRC_EXPIRED = 3'd3;
   localparam logic [2:0] SRC_FIXED   = 3'd7;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_BAD_POLICY = 2'd1;
   localparam logic [1:0] STAT_NO_RATE    = 2'd2;
   localparam logic [1:0] STAT_BAD_LINKS  = 2'd3;

   localparam logic [2:0] CSR_LINK_COUNT = 3'd0;
   localparam logic [2:0] CSR_POLICY     = 3'd1;
   localparam logic [2:0] CSR_RATE0      = 3'd2;
   localparam logic [2:0] CSR_RATE1      = 3'd3;
   localparam logic [2:0] CSR_RATE2      = 3'd4;
   localparam logic [2:0] CSR_FIXED0     = 3'd5;
   localparam logic [2:0] CSR_FIXED1     = 3'd6;
   localparam logic [2:0] CSR_FIXED2     = 3'd7;

   typedef struct packed {
      logic [1:0]       operation;
      logic [1:0]       link_id;
      logic [NOW_W-1:0] now_us;
      logic [15:0]      duration_us;
      logic             is_qos_data;
      logic [10:0]      baw_size;
      logic [15:0]      extra_time_us;
   } req_type;

   typedef struct packed {
      logic [31:0] limit;
      logic [2:0]  source;
      logic        in_window;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [LINK_W-1:0] link;
      logic [NOW_W-1:0]  now;
      logic [15:0]       dur;
      logic [10:0]       baw;
      logic [15:0]       extra;
   } cmd_type;

   typedef struct packed {
      logic [1:0]                  link_count;
      logic [2:0]                  policy;
      logic [MAX_LINKS-1:0][31:0] frame_rate;
      logic [MAX_LINKS-1:0][31:0] fixed_limit;
   } cfg_type;

endpackage

### src/malc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module malc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/malc_front.sv
// Front end: accepts request beats, classifies them and queues commands.
// Depends on malc_pkg.
module malc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  malc_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output malc_pkg::cmd_type cmd_data
);

   malc_pkg::cmd_type                       q_ff [malc_pkg::CMDQ_DEPTH];
   logic [malc_pkg::CMDQ_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [malc_pkg::CMDQ_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [malc_pkg::CMDQ_CNT_W-1:0]         count_ff, count_in;
   logic                                    keep;
   logic                                    do_wr, do_rd;
   malc_pkg::cmd_type                       cmd_new;

   always_comb begin
      cmd_new.link  = req_data.link_id;
      cmd_new.now   = req_data.now_us;
      cmd_new.dur   = req_data.duration_us;
      cmd_new.baw   = req_data.baw_size;
      cmd_new.extra = req_data.extra_time_us;
      cmd_new.kind  = malc_pkg::CMD_NOTICE;
      keep          = 1'b0;
      unique case (req_data.operation)
         malc_pkg::OP_NOTICE: begin
            keep = req_data.is_qos_data &&
                   (req_data.link_id < malc_pkg::LINK_W'(malc_pkg::MAX_LINKS));
         end
         malc_pkg::OP_LIMIT: begin
            cmd_new.kind = malc_pkg::CMD_LIMIT;
            keep         = 1'b1;
         end
         malc_pkg::OP_WINDOW: begin
            cmd_new.kind = malc_pkg::CMD_WINDOW;
            keep         = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_full  = (count_ff == malc_pkg::CMDQ_CNT_W'(malc_pkg::CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign do_wr     = req_push && !req_full && keep;
   assign do_rd     = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == malc_pkg::CMDQ_PTR_W'(malc_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == malc_pkg::CMDQ_PTR_W'(malc_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

### src/malc_back.sv
// Back end: per-link window and gap state, limit and window decisions,
// shared bit-serial divider and 32x32 multiply-accumulate, result register.
// Depends on malc_pkg and malc_ram.
module malc_back (
   input  logic              clock,
   input  logic              reset,
   input  malc_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  malc_pkg::cmd_type cmd_data,
   output logic              out_valid,
   input  logic              out_pop,
   output malc_pkg::rsp_type out_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_NOTE   = 4'd1;
   localparam logic [3:0] S_NAPPLY = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_DIVO   = 4'd4;
   localparam logic [3:0] S_DIVT   = 4'd5;
   localparam logic [3:0] S_GATE   = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_NCHK   = 4'd8;
   localparam logic [3:0] S_NDIV   = 4'd9;
   localparam logic [3:0] S_TSUM   = 4'd10;
   localparam logic [3:0] S_ROUND  = 4'd11;

   localparam logic [4:0] MSTEP_S   = 5'd1;
   localparam logic [4:0] MSTEP_D   = 5'd2;
   localparam logic [4:0] MSTEP_RR  = 5'd3;
   localparam logic [4:0] MSTEP_NUM = 5'd14;
   localparam logic [4:0] MSTEP_T0  = 5'd15;
   localparam logic [4:0] MSTEP_END = 5'd17;

   logic [3:0] state_ff, state_in;
   malc_pkg::cmd_type cmd_ff, cmd_in;

   logic [malc_pkg::NOW_W-1:0]     ws_ff [malc_pkg::MAX_LINKS];
   logic [malc_pkg::NOW_W-1:0]     we_ff [malc_pkg::MAX_LINKS];
   logic [malc_pkg::GAP_CNT_W-1:0] gcount_ff [malc_pkg::MAX_LINKS];
   logic [malc_pkg::GAP_IDX_W-1:0] gnext_ff [malc_pkg::MAX_LINKS];
   logic [malc_pkg::GAP_SUM_W-1:0] gsum_ff [malc_pkg::MAX_LINKS];

   logic                        link_we;
   logic [malc_pkg::NOW_W-1:0]     ws_in, we_in;
   logic [malc_pkg::GAP_CNT_W-1:0] gcount_in;
   logic [malc_pkg::GAP_IDX_W-1:0] gnext_in;
   logic [malc_pkg::GAP_SUM_W-1:0] gsum_in;

   logic                  out_valid_ff, out_valid_in;
   malc_pkg::rsp_type     out_ff, out_in;

   logic [malc_pkg::DIV_N_W-1:0]   div_num_ff, div_num_in;
   logic [malc_pkg::DIV_D_W-1:0]   div_rem_ff, div_rem_in;
   logic [malc_pkg::DIV_D_W-1:0]   div_den_ff, div_den_in;
   logic [malc_pkg::DIV_N_W-1:0]   div_q_ff, div_q_in;
   logic [malc_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [malc_pkg::DIV_D_W:0]     rem_sh, rem_sub;
   logic                           rem_ge;

   logic [malc_pkg::MEAN_W-1:0] mean_o_ff, mean_o_in;
   logic [malc_pkg::OH_W-1:0]   oh_o_ff, oh_o_in, oh_t_ff, oh_t_in;
   logic                        cnt_o_nz_ff, cnt_o_nz_in;
   logic [malc_pkg::NOW_W-1:0]  we_o_ff, we_o_in;
   logic [malc_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic [malc_pkg::DIV_D_W-1:0] s_ff, s_in, d_ff, d_in;
   logic [63:0]                 rr_ff, rr_in;
   logic [malc_pkg::T_W-1:0]    t_ff, t_in;
   logic [malc_pkg::ACC_W-1:0]  acc_ff, acc_in, acc_nx, mul_term;
   logic [63:0]                 prod_ff, prod_in;
   logic [4:0]                  mstep_ff, mstep_in;
   logic                        mphase_ff, mphase_in;
   logic [31:0]                 mul_a, mul_b;
   logic [6:0]                  mul_sh;
   logic                        mul_neg;

   logic [malc_pkg::LINK_W-1:0]    oth_link, rd_link;
   logic [malc_pkg::NOW_W-1:0]     ws_rd, we_rd;
   logic [malc_pkg::GAP_CNT_W-1:0] gcount_rd;
   logic [malc_pkg::GAP_IDX_W-1:0] gnext_rd;
   logic [malc_pkg::GAP_SUM_W-1:0] gsum_rd;
   logic [31:0]                    rt, r0, r1;

   logic [malc_pkg::GAP_RAM_AW-1:0] gap_addr;
   logic                            ram_we;
   logic [31:0]                     ram_wdata, ram_rdata;

   logic [malc_pkg::NOW_W:0]       end_sum, now_minus;
   logic [malc_pkg::NOW_W-1:0]     end_sat;
   logic [31:0]                    gap32, old_gap;
   logic                           has_gap, ring_full;
   malc_pkg::rsp_type              res;
   logic                           start_adapt;
   logic [malc_pkg::MEAN_W-1:0]    mean_q;
   logic [malc_pkg::DIFF_W-1:0]    a_val, b_val;
   logic [malc_pkg::T_W-1:0]       q_clamp, x_val;
   logic [64:0]                    lim_q;

   assign oth_link = {1'b0, ~cmd_ff.link[0]};
   assign rd_link  = (state_ff == S_NOTE || state_ff == S_NAPPLY || state_ff == S_DIVO ||
                      state_ff == S_DIVT) ? cmd_ff.link : oth_link;
   assign ws_rd     = ws_ff[rd_link];
   assign we_rd     = we_ff[rd_link];
   assign gcount_rd = gcount_ff[rd_link];
   assign gnext_rd  = gnext_ff[rd_link];
   assign gsum_rd   = gsum_ff[rd_link];
   assign r0 = cfg.frame_rate[0];
   assign r1 = cfg.frame_rate[1];
   assign rt = cfg.frame_rate[cmd_ff.link];

   assign gap_addr = malc_pkg::GAP_RAM_AW'(cmd_ff.link) *
                     malc_pkg::GAP_RAM_AW'(malc_pkg::GAP_HISTORY) +
                     malc_pkg::GAP_RAM_AW'(gnext_rd);

   malc_ram #(
      .WIDTH (32),
      .DEPTH (malc_pkg::GAP_RAM_DEPTH)
   ) u_gap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (gap_addr),
      .wr_data (ram_wdata),
      .rd_addr (gap_addr),
      .rd_data (ram_rdata)
   );

   // transmit notice arithmetic
   always_comb begin
      end_sum   = {1'b0, cmd_ff.now} + (malc_pkg::NOW_W + 1)'(cmd_ff.dur);
      end_sat   = end_sum[malc_pkg::NOW_W] ? '1 : end_sum[malc_pkg::NOW_W-1:0];
      has_gap   = (we_rd != '0) && (cmd_ff.now > we_rd);
      now_minus = {1'b0, cmd_ff.now} - {1'b0, we_rd};
      gap32     = (now_minus[malc_pkg::NOW_W:32] != '0) ? '1 : now_minus[31:0];
      ring_full = (gcount_rd >= malc_pkg::GAP_CNT_W'(malc_pkg::GAP_HISTORY));
      old_gap   = ring_full ? ram_rdata : '0;
      ram_wdata = gap32;
   end

   // divider step
   always_comb begin
      rem_sh  = {div_rem_ff, div_num_ff[malc_pkg::DIV_N_W-1]};
      rem_ge  = (rem_sh >= {1'b0, div_den_ff});
      rem_sub = rem_sh - {1'b0, div_den_ff};
   end

   // multiply program
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_sh  = 7'd0;
      mul_neg = 1'b0;
      unique case (mstep_ff)
         5'd0:  begin mul_a = r0; mul_b = r0; end
         5'd1:  begin mul_a = r1; mul_b = r1; end
         5'd2:  begin mul_a = r0; mul_b = r1; end
         5'd3:  begin mul_a = rt; mul_b = rt; end
         5'd4:  begin mul_a = 32'(cmd_ff.baw); mul_b = rt; mul_sh = 7'd36; end
         5'd5:  begin mul_a = s_ff[31:0]; mul_b = oh_t_ff[31:0]; end
         5'd6:  begin
            mul_a = s_ff[31:0]; mul_b = 32'(oh_t_ff[malc_pkg::OH_W-1:32]); mul_sh = 7'd32;
         end
         5'd7:  begin mul_a = s_ff[63:32]; mul_b = oh_t_ff[31:0]; mul_sh = 7'd32; end
         5'd8:  begin
            mul_a = s_ff[63:32]; mul_b = 32'(oh_t_ff[malc_pkg::OH_W-1:32]); mul_sh = 7'd64;
         end
         5'd9:  begin
            mul_a = 32'(s_ff[malc_pkg::DIV_D_W-1:64]); mul_b = oh_t_ff[31:0]; mul_sh = 7'd64;
         end
         5'd10: begin
            mul_a = 32'(s_ff[malc_pkg::DIV_D_W-1:64]);
            mul_b = 32'(oh_t_ff[malc_pkg::OH_W-1:32]);
            mul_sh = 7'd96;
         end
         5'd11: begin mul_a = rr_ff[31:0]; mul_b = oh_o_ff[31:0]; mul_neg = 1'b1; end
         5'd12: begin
            mul_a = rr_ff[31:0]; mul_b = 32'(oh_o_ff[malc_pkg::OH_W-1:32]);
            mul_sh = 7'd32; mul_neg = 1'b1;
         end
         5'd13: begin
            mul_a = rr_ff[63:32]; mul_b = oh_o_ff[31:0]; mul_sh = 7'd32; mul_neg = 1'b1;
         end
         5'd14: begin
            mul_a = rr_ff[63:32]; mul_b = 32'(oh_o_ff[malc_pkg::OH_W-1:32]);
            mul_sh = 7'd64; mul_neg = 1'b1;
         end
         5'd15: begin mul_a = t_ff[31:0]; mul_b = rt; end
         5'd16: begin mul_a = t_ff[63:32]; mul_b = rt; mul_sh = 7'd32; end
         5'd17: begin
            mul_a = 32'(t_ff[malc_pkg::T_W-1:64]); mul_b = rt; mul_sh = 7'd64;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      mul_term = malc_pkg::ACC_W'(prod_ff) << mul_sh;
      acc_nx   = mul_neg ? acc_ff - mul_term : acc_ff + mul_term;
   end

   // limit and window decision
   always_comb begin
      res         = '0;
      start_adapt = 1'b0;
      if (cmd_ff.kind == malc_pkg::CMD_WINDOW) begin
         if (cfg.link_count != 2'd2) begin
            res.status = malc_pkg::STAT_BAD_LINKS;
         end else if (cmd_ff.link <= 2'd1) begin
            res.in_window = (ws_rd < cmd_ff.now) &&
                            ({1'b0, cmd_ff.now} <
                             {1'b0, we_rd} + (malc_pkg::NOW_W + 1)'(cmd_ff.extra));
         end
      end else if (cfg.link_count != 2'd2 && cfg.link_count != 2'd3) begin
         res.status = malc_pkg::STAT_BAD_LINKS;
      end else if (cmd_ff.link < cfg.link_count) begin
         unique case (cfg.policy)
            malc_pkg::POL_GREEDY: begin
               res.limit  = malc_pkg::UNLIMITED;
               res.source = malc_pkg::SRC_GREEDY;
            end
            malc_pkg::POL_ADAPTIVE: begin
               if (cfg.link_count != 2'd2) begin
                  res.status = malc_pkg::STAT_BAD_POLICY;
               end else begin
                  res.source = malc_pkg::SRC_ADAPT;
                  if (r0 == '0 || r1 == '0) begin
                     res.status = malc_pkg::STAT_NO_RATE;
                  end else if (cmd_ff.now < malc_pkg::BOOTSTRAP_US) begin
                     res.limit  = 32'(({1'b0, cmd_ff.baw} + 12'd1) >> 1);
                     res.source = malc_pkg::SRC_BOOT;
                  end else begin
                     start_adapt = 1'b1;
                  end
               end
            end
            malc_pkg::POL_ONLY0, malc_pkg::POL_ONLY1, malc_pkg::POL_ONLY2: begin
               if (cfg.policy == malc_pkg::POL_ONLY2 && cfg.link_count != 2'd3) begin
                  res.status = malc_pkg::STAT_BAD_POLICY;
               end else begin
                  res.limit  = ({1'b0, cmd_ff.link} == cfg.policy - malc_pkg::POL_ONLY0) ?
                               malc_pkg::UNLIMITED : '0;
                  res.source = cfg.policy + 3'd1;
               end
            end
            malc_pkg::POL_FIXED: begin
               res.limit  = cfg.fixed_limit[cmd_ff.link];
               res.source = malc_pkg::SRC_FIXED;
            end
            default: res.status = malc_pkg::STAT_BAD_POLICY;
         endcase
      end
   end

   always_comb begin
      mean_q  = div_q_ff[malc_pkg::MEAN_W-1:0];
      a_val   = {1'b0, we_o_ff, 8'd0} + malc_pkg::DIFF_W'(mean_o_ff);
      b_val   = {1'b0, cmd_ff.now, 8'd0};
      q_clamp = (div_q_ff[malc_pkg::DIV_N_W-1:malc_pkg::T_W-1] != '0) ?
                {1'b1, {(malc_pkg::T_W-1){1'b0}}} : div_q_ff[malc_pkg::T_W-1:0];
      x_val   = (q_clamp > malc_pkg::T_W'(oh_t_ff)) ? q_clamp - malc_pkg::T_W'(oh_t_ff) : '0;
      lim_q   = {1'b0, acc_ff[99:36]} + 65'(acc_ff[35:0] != '0);
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cmd_pop      = 1'b0;
      out_valid_in = out_valid_ff && !out_pop;
      out_in       = out_ff;
      link_we      = 1'b0;
      ws_in        = ws_rd;
      we_in        = we_rd;
      gcount_in    = gcount_rd;
      gnext_in     = gnext_rd;
      gsum_in      = gsum_rd;
      ram_we       = 1'b0;
      mean_o_in    = mean_o_ff;
      oh_o_in      = oh_o_ff;
      oh_t_in      = oh_t_ff;
      cnt_o_nz_in  = cnt_o_nz_ff;
      we_o_in      = we_o_ff;
      diff_in      = diff_ff;
      s_in         = s_ff;
      d_in         = d_ff;
      rr_in        = rr_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      mstep_in     = mstep_ff;
      mphase_in    = mphase_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_q_in     = div_q_ff;
      div_cnt_in   = div_cnt_ff;
      if (div_cnt_ff != '0) begin
         div_num_in = div_num_ff << 1;
         div_rem_in = rem_ge ? rem_sub[malc_pkg::DIV_D_W-1:0] : rem_sh[malc_pkg::DIV_D_W-1:0];
         div_q_in   = {div_q_ff[malc_pkg::DIV_N_W-2:0], rem_ge};
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && (cmd_data.kind == malc_pkg::CMD_NOTICE || !out_valid_ff)) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               state_in = (cmd_data.kind == malc_pkg::CMD_NOTICE) ? S_NOTE : S_DECIDE;
            end
         end
         S_NOTE: state_in = S_NAPPLY;
         S_NAPPLY: begin
            link_we = 1'b1;
            ws_in   = cmd_ff.now;
            we_in   = end_sat;
            if (has_gap) begin
               ram_we    = 1'b1;
               gsum_in   = gsum_rd - malc_pkg::GAP_SUM_W'(old_gap) +
                           malc_pkg::GAP_SUM_W'(gap32);
               gcount_in = ring_full ? gcount_rd : gcount_rd + 1'b1;
               gnext_in  = (gnext_rd == malc_pkg::GAP_IDX_W'(malc_pkg::GAP_HISTORY - 1)) ?
                           '0 : gnext_rd + 1'b1;
            end
            state_in = S_IDLE;
         end
         S_DECIDE: begin
            if (start_adapt) begin
               we_o_in     = we_rd;
               cnt_o_nz_in = (gcount_rd != '0);
               div_num_in  = {gsum_rd, 8'd0, {(malc_pkg::DIV_N_W - malc_pkg::MEAN_W){1'b0}}};
               div_den_in  = malc_pkg::DIV_D_W'(gcount_rd);
               div_rem_in  = '0;
               div_q_in    = '0;
               div_cnt_in  = malc_pkg::DIV_CNT_W'(malc_pkg::MEAN_W);
               state_in    = S_DIVO;
            end else begin
               out_valid_in = 1'b1;
               out_in       = res;
               state_in     = S_IDLE;
            end
         end
         S_DIVO: begin
            if (div_cnt_ff == '0) begin
               mean_o_in  = cnt_o_nz_ff ? mean_q : '0;
               oh_o_in    = cnt_o_nz_ff ? malc_pkg::OH_W'(mean_q) + malc_pkg::PHY_OH_Q8 : '0;
               div_num_in = {gsum_rd, 8'd0, {(malc_pkg::DIV_N_W - malc_pkg::MEAN_W){1'b0}}};
               div_den_in = malc_pkg::DIV_D_W'(gcount_rd);
               div_rem_in = '0;
               div_q_in   = '0;
               div_cnt_in = malc_pkg::DIV_CNT_W'(malc_pkg::MEAN_W);
               state_in   = S_DIVT;
            end
         end
         S_DIVT: begin
            if (div_cnt_ff == '0) begin
               oh_t_in  = (gcount_rd != '0) ?
                          malc_pkg::OH_W'(mean_q) + malc_pkg::PHY_OH_Q8 : '0;
               state_in = S_GATE;
            end
         end
         S_GATE: begin
            if (a_val <= b_val) begin
               out_valid_in = 1'b1;
               out_in       = '0;
               out_in.limit = malc_pkg::UNLIMITED;
               out_in.source = malc_pkg::SRC_EXPIRED;
               state_in     = S_IDLE;
            end else begin
               diff_in   = a_val - b_val;
               acc_in    = '0;
               mstep_in  = '0;
               mphase_in = 1'b0;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (!mphase_ff) begin
               prod_in   = mul_a * mul_b;
               mphase_in = 1'b1;
            end else begin
               acc_in    = acc_nx;
               mphase_in = 1'b0;
               mstep_in  = mstep_ff + 1'b1;
               if (mstep_ff == MSTEP_S) begin
                  s_in = acc_nx[malc_pkg::DIV_D_W-1:0];
               end
               if (mstep_ff == MSTEP_D) begin
                  d_in   = acc_nx[malc_pkg::DIV_D_W-1:0];
                  acc_in = '0;
               end
               if (mstep_ff == MSTEP_RR) begin
                  rr_in  = acc_nx[63:0];
                  acc_in = '0;
               end
               if (mstep_ff == MSTEP_NUM) begin
                  state_in = S_NCHK;
               end
               if (mstep_ff == MSTEP_END) begin
                  state_in = S_ROUND;
               end
            end
         end
         S_NCHK: begin
            if (!acc_ff[malc_pkg::ACC_W-1] && acc_ff != '0) begin
               div_num_in = acc_ff[malc_pkg::DIV_N_W-1:0];
               div_den_in = d_ff;
               div_rem_in = '0;
               div_q_in   = '0;
               div_cnt_in = malc_pkg::DIV_CNT_W'(malc_pkg::DIV_N_W);
               state_in   = S_NDIV;
            end else begin
               div_q_in = '0;
               state_in = S_TSUM;
            end
         end
         S_NDIV: begin
            if (div_cnt_ff == '0) begin
               state_in = S_TSUM;
            end
         end
         S_TSUM: begin
            t_in      = malc_pkg::T_W'(diff_ff) + x_val;
            acc_in    = '0;
            mstep_in  = MSTEP_T0;
            mphase_in = 1'b0;
            state_in  = S_MUL;
         end
         S_ROUND: begin
            out_valid_in  = 1'b1;
            out_in        = '0;
            out_in.source = malc_pkg::SRC_ADAPT;
            if (acc_ff[malc_pkg::ACC_W-1:100] != '0 || lim_q[64:32] != '0) begin
               out_in.limit = malc_pkg::UNLIMITED;
            end else begin
               out_in.limit = lim_q[31:0];
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
         for (int i = 0; i < malc_pkg::MAX_LINKS; i++) begin
            ws_ff[i]     <= '0;
            we_ff[i]     <= '0;
            gcount_ff[i] <= '0;
            gnext_ff[i]  <= '0;
            gsum_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         div_cnt_ff   <= div_cnt_in;
         if (link_we) begin
            ws_ff[cmd_ff.link]     <= ws_in;
            we_ff[cmd_ff.link]     <= we_in;
            gcount_ff[cmd_ff.link] <= gcount_in;
            gnext_ff[cmd_ff.link]  <= gnext_in;
            gsum_ff[cmd_ff.link]   <= gsum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      out_ff      <= out_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_q_ff    <= div_q_in;
      mean_o_ff   <= mean_o_in;
      oh_o_ff     <= oh_o_in;
      oh_t_ff     <= oh_t_in;
      cnt_o_nz_ff <= cnt_o_nz_in;
      we_o_ff     <= we_o_in;
      diff_ff     <= diff_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      rr_ff       <= rr_in;
      t_ff        <= t_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      mstep_ff    <= mstep_in;
      mphase_ff   <= mphase_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

### src/multilink_aggregate_limit_controller.sv
// Top level: configuration registers, front end queue and back end engine.
// Depends on malc_pkg, malc_front, malc_back.
//
//   channel   ports                         beat
//   request   req_push / req_full           req_data (operation .. extra_time_us)
//   response  rsp_empty / rsp_pop           rsp_data (limit, source, in_window, status)
//   csr       csr_write, csr_index          csr_wdata, no wait, no read-back
//
// Notices pass the NOTE and NAPPLY states; window checks and non-adaptive limits
// are settled in DECIDE. Adaptive limits use the shared 1-bit-per-cycle divider
// (44 + 44 + 112 steps) and the 32x32 multiplier (18 products).
// A 2-entry command queue takes beats while the engine works or a result waits.
// Reset is synchronous and clears the link windows, gap counts and sums.
module multilink_aggregate_limit_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  malc_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output malc_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   logic [1:0]  link_count_ff;
   logic [2:0]  policy_ff;
   logic [31:0] rate_ff [malc_pkg::MAX_LINKS];
   logic [31:0] fixed_ff [malc_pkg::MAX_LINKS];
   malc_pkg::cfg_type cfg;
   malc_pkg::cmd_type cmd_data;
   logic cmd_valid, cmd_pop, out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_count_ff <= 2'd2;
         policy_ff     <= malc_pkg::POL_GREEDY;
         for (int i = 0; i < malc_pkg::MAX_LINKS; i++) begin
            rate_ff[i]  <= '0;
            fixed_ff[i] <= malc_pkg::UNLIMITED;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            malc_pkg::CSR_LINK_COUNT: link_count_ff <= csr_wdata[1:0];
            malc_pkg::CSR_POLICY:     policy_ff     <= csr_wdata[2:0];
            malc_pkg::CSR_RATE0:      rate_ff[0]    <= csr_wdata;
            malc_pkg::CSR_RATE1:      rate_ff[1]    <= csr_wdata;
            malc_pkg::CSR_RATE2:      rate_ff[2]    <= csr_wdata;
            malc_pkg::CSR_FIXED0:     fixed_ff[0]   <= csr_wdata;
            malc_pkg::CSR_FIXED1:     fixed_ff[1]   <= csr_wdata;
            malc_pkg::CSR_FIXED2:     fixed_ff[2]   <= csr_wdata;
            default:                  policy_ff     <= policy_ff;
         endcase
      end
   end

   always_comb begin
      cfg.link_count = link_count_ff;
      cfg.policy     = policy_ff;
      for (int i = 0; i < malc_pkg::MAX_LINKS; i++) begin
         cfg.frame_rate[i]  = rate_ff[i];
         cfg.fixed_limit[i] = fixed_ff[i];
      end
   end

   malc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   malc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .out_valid (out_valid),
      .out_pop   (rsp_pop),
      .out_data  (rsp_data)
   );

   assign rsp_empty = !out_valid;

endmodule
